### hw/rtl/pwag_pkg.sv
package pwag_pkg;

  // Field and register widths
  localparam int SampleW = 16;
  localparam int MagW    = 17;
  localparam int RootW   = 16;
  localparam int GainW   = 18;
  localparam int CountW  = 20;
  localparam int CfgW    = 20;
  localparam int CfgIdxW = 2;
  localparam int AccW    = 34;
  localparam int WeightW = 16;
  localparam int SubW    = 20;
  localparam int StepW   = 5;

  // Register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] RegWindowLength  = 2'd0;
  localparam logic [CfgIdxW-1:0] RegGainNumerator = 2'd1;
  localparam logic [CfgIdxW-1:0] RegGainFloor     = 2'd2;

  // Register reset values
  localparam logic [CountW-1:0] WindowLengthRst  = 20'd96000;
  localparam logic [GainW-1:0]  GainNumeratorRst = 18'd154202;
  localparam logic [GainW-1:0]  GainFloorRst     = 18'd3277;

  // Unity gain in Q2.16
  localparam logic [GainW-1:0] GainOne = 18'd65536;

  // Smoothing weights, 0.99 and 0.01 in Q0.16; they sum to 65536
  localparam logic [WeightW-1:0] AvgKeepWeight = 16'd64881;
  localparam logic [WeightW-1:0] AvgNewWeight  = 16'd655;

  // Iteration counts of the shared compare-subtract unit
  localparam int SqrtSteps = 16;
  localparam int DivSteps  = GainW;

endpackage

### hw/rtl/peak_window_audio_gain.sv
// Peak-window audio gain estimator.
//
// Input channel (in_valid_i / in_stall_o) takes one complex sample word per
// handshake: sample_i_i and sample_q_i, two's complement. Output channel
// (out_valid_o / out_stall_i) carries one smoothed_gain_o word, unsigned
// Q2.16, on the last sample of each window; other samples give no word.
// The configuration port writes window_length, gain_numerator and gain_floor
// by index on any cycle with cfg_we_i high; write only while the block idles.
//
// Sequence: a sample is taken in the idle state and squared on the shared
// multiplier (I^2, then Q^2). It then passes through 16 iterations of the
// shared compare-subtract unit for the integer square root, and the root
// updates the peak and the sample count. A window-ending sample adds
// 18 divide iterations on the same compare-subtract unit, a clamp step,
// the average on the shared multiplier (keep term, then new term) and a
// step that loads the output register, which drives out_valid_o.
// A window that ends on a zero peak skips the divide.
// in_stall_o stays high while a sample is in work.
// A receiver stall holds the output word; the block keeps taking samples
// until it has a new word to load while the old one still waits.
// Reset (rst_ni low) restores register defaults, clears peak and count, and
// sets the average gain to 1.0.
module peak_window_audio_gain (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic signed [pwag_pkg::SampleW-1:0] sample_i_i,
  input  logic signed [pwag_pkg::SampleW-1:0] sample_q_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [pwag_pkg::GainW-1:0]      smoothed_gain_o,
  input  logic                            cfg_we_i,
  input  logic [pwag_pkg::CfgIdxW-1:0]    cfg_index_i,
  input  logic [pwag_pkg::CfgW-1:0]       cfg_data_i
);
  import pwag_pkg::*;

  typedef enum logic [3:0] {
    StIdle,
    StSqI,
    StSqQ,
    StSqrt,
    StUpdate,
    StDiv,
    StClamp,
    StMulKeep,
    StMulNew,
    StPush
  } state_e;

  state_e state_q, state_d;

  // Configuration registers
  logic [CountW-1:0] len_q, len_d;
  logic [GainW-1:0]  num_q, num_d;
  logic [GainW-1:0]  floor_q, floor_d;

  // Block state
  logic [MagW-1:0]   peak_q, peak_d;
  logic [CountW-1:0] count_q, count_d;
  logic [GainW-1:0]  raw_q, raw_d;    // raw gain; doubles as quotient shifter
  logic [GainW-1:0]  avg_q, avg_d;

  // Working registers
  logic [SampleW-1:0] ai_q, ai_d;
  logic [SampleW-1:0] aq_q, aq_d;
  logic [AccW-1:0]    acc_q, acc_d;   // sum of squares, radicand, products
  logic [GainW-1:0]   rem_q, rem_d;   // square root and divide remainder
  logic [RootW-1:0]   root_q, root_d;
  logic [StepW-1:0]   steps_q, steps_d;

  // Output register
  logic              out_valid_q, out_valid_d;
  logic [GainW-1:0]  gain_out_q, gain_out_d;

  // Shared units
  logic [GainW-1:0]   mul_a;
  logic [WeightW-1:0] mul_b;
  logic [AccW-1:0]    mul_p;
  logic [SubW-1:0]    sub_a, sub_b;
  logic [SubW:0]      sub_diff;
  logic               sub_ge;

  // Helpers
  logic [SampleW-1:0] abs_i, abs_q;
  logic [SubW-1:0]    sqrt_rem_sh;
  logic [GainW-1:0]   div_rem_sh;
  logic [MagW-1:0]    mag, peak_new;
  logic [CountW-1:0]  count_inc;
  logic               out_free;

  assign abs_i = sample_i_i[SampleW-1] ? (~sample_i_i + SampleW'(1)) : sample_i_i;
  assign abs_q = sample_q_i[SampleW-1] ? (~sample_q_i + SampleW'(1)) : sample_q_i;

  // Bring down the next two radicand bits, or the next dividend bit
  assign sqrt_rem_sh = {rem_q, acc_q[31:30]};
  assign div_rem_sh  = {rem_q[GainW-2:0], raw_q[GainW-1]};

  assign mag       = {1'b0, root_q};
  assign peak_new  = (mag > peak_q) ? mag : peak_q;
  assign count_inc = count_q + CountW'(1);
  assign out_free  = !out_valid_q || !out_stall_i;

  // Operand select for the shared multiplier and compare-subtract unit
  always_comb begin
    mul_a = {2'b00, ai_q};
    mul_b = ai_q;
    sub_a = sqrt_rem_sh;
    sub_b = {2'b00, root_q, 2'b01};
    unique case (state_q)
      StSqQ: begin
        mul_a = {2'b00, aq_q};
        mul_b = aq_q;
      end
      StMulKeep: begin
        mul_a = avg_q;
        mul_b = AvgKeepWeight;
      end
      StMulNew: begin
        mul_a = raw_q;
        mul_b = AvgNewWeight;
      end
      StDiv: begin
        sub_a = {2'b00, div_rem_sh};
        sub_b = {3'b000, peak_q};
      end
      default: begin
      end
    endcase
  end

  assign mul_p    = AccW'(mul_a) * AccW'(mul_b);
  assign sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
  assign sub_ge   = !sub_diff[SubW];

  always_comb begin
    state_d     = state_q;
    len_d       = len_q;
    num_d       = num_q;
    floor_d     = floor_q;
    peak_d      = peak_q;
    count_d     = count_q;
    raw_d       = raw_q;
    avg_d       = avg_q;
    ai_d        = ai_q;
    aq_d        = aq_q;
    acc_d       = acc_q;
    rem_d       = rem_q;
    root_d      = root_q;
    steps_d     = steps_q;
    out_valid_d = out_valid_q;
    gain_out_d  = gain_out_q;

    // Drop the output word once taken
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (in_valid_i) begin
          ai_d    = abs_i;
          aq_d    = abs_q;
          state_d = StSqI;
        end
      end
      StSqI: begin
        acc_d   = mul_p;
        state_d = StSqQ;
      end
      StSqQ: begin
        acc_d   = acc_q + mul_p;
        rem_d   = '0;
        root_d  = '0;
        steps_d = StepW'(SqrtSteps - 1);
        state_d = StSqrt;
      end
      StSqrt: begin
        // One root bit per step
        if (sub_ge) begin
          rem_d  = sub_diff[GainW-1:0];
          root_d = {root_q[RootW-2:0], 1'b1};
        end else begin
          rem_d  = sqrt_rem_sh[GainW-1:0];
          root_d = {root_q[RootW-2:0], 1'b0};
        end
        acc_d = {acc_q[AccW-3:0], 2'b00};
        if (steps_q == '0) begin
          state_d = StUpdate;
        end else begin
          steps_d = steps_q - StepW'(1);
        end
      end
      StUpdate: begin
        peak_d = peak_new;
        if (count_inc < len_q) begin
          count_d = count_inc;
          state_d = StIdle;
        end else begin
          count_d = '0;
          if (peak_new != '0) begin
            // Load the dividend into the quotient shifter
            raw_d   = num_q;
            rem_d   = '0;
            steps_d = StepW'(DivSteps - 1);
            state_d = StDiv;
          end else begin
            // Zero peak: keep the previous raw gain
            state_d = StClamp;
          end
        end
      end
      StDiv: begin
        if (sub_ge) begin
          rem_d = sub_diff[GainW-1:0];
        end else begin
          rem_d = div_rem_sh;
        end
        raw_d = {raw_q[GainW-2:0], sub_ge};
        if (steps_q == '0) begin
          state_d = StClamp;
        end else begin
          steps_d = steps_q - StepW'(1);
        end
      end
      StClamp: begin
        if (raw_q <= floor_q) begin
          raw_d = floor_q;
        end
        peak_d  = '0;
        state_d = StMulKeep;
      end
      StMulKeep: begin
        acc_d   = mul_p;
        state_d = StMulNew;
      end
      StMulNew: begin
        acc_d   = acc_q + mul_p;
        state_d = StPush;
      end
      StPush: begin
        // Hold here until the output register frees up
        if (out_free) begin
          gain_out_d  = acc_q[AccW-1:AccW-GainW];
          avg_d       = acc_q[AccW-1:AccW-GainW];
          raw_d       = acc_q[AccW-1:AccW-GainW];
          out_valid_d = 1'b1;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase

    if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegWindowLength:  len_d   = cfg_data_i;
        RegGainNumerator: num_d   = cfg_data_i[GainW-1:0];
        RegGainFloor:     floor_d = cfg_data_i[GainW-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      len_q       <= WindowLengthRst;
      num_q       <= GainNumeratorRst;
      floor_q     <= GainFloorRst;
      peak_q      <= '0;
      count_q     <= '0;
      raw_q       <= GainOne;
      avg_q       <= GainOne;
      steps_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      len_q       <= len_d;
      num_q       <= num_d;
      floor_q     <= floor_d;
      peak_q      <= peak_d;
      count_q     <= count_d;
      raw_q       <= raw_d;
      avg_q       <= avg_d;
      steps_q     <= steps_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath registers, no reset
  always_ff @(posedge clk_i) begin
    ai_q       <= ai_d;
    aq_q       <= aq_d;
    acc_q      <= acc_d;
    rem_q      <= rem_d;
    root_q     <= root_d;
    gain_out_q <= gain_out_d;
  end

  assign in_stall_o      = (state_q != StIdle);
  assign out_valid_o     = out_valid_q;
  assign smoothed_gain_o = gain_out_q;

endmodule

### hw/rtl/pwag_checker.sv
module pwag_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_stall_o,
  input logic signed [pwag_pkg::SampleW-1:0] sample_i_i,
  input logic signed [pwag_pkg::SampleW-1:0] sample_q_i,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic [pwag_pkg::GainW-1:0]      smoothed_gain_o,
  input logic                            cfg_we_i,
  input logic [pwag_pkg::CfgIdxW-1:0]    cfg_index_i,
  input logic [pwag_pkg::CfgW-1:0]       cfg_data_i
);
  import pwag_pkg::*;

  logic in_fire;
  assign in_fire = in_valid_i && !in_stall_o;

  // A stalled output word holds its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(smoothed_gain_o))
    else $error("output word changed under stall");

  // An accepted sample keeps the block busy on the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> in_stall_o)
    else $error("block ready right after taking a sample");

  // A new output word only appears from work in progress
  a_word_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("output word without a sample in work");

endmodule

bind peak_window_audio_gain pwag_checker u_pwag_checker (.*);
